/* hdl/dgc_pkg.sv */
// ----------------------------------------------------------------------------
// dgc_pkg: shared types and codes of the drag gesture classifier
// Field widths, event and gesture codes, register map and reset values.
// ----------------------------------------------------------------------------
package dgc_pkg;

    localparam int MODE_W     = 2;
    localparam int BTN_W      = 3;
    localparam int KIND_W     = 2;
    localparam int GEST_W     = 2;
    localparam int TOL_W      = 16;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [MODE_W-1:0]     t_mode;
    typedef logic [BTN_W-1:0]      t_btn;
    typedef logic [KIND_W-1:0]     t_kind;
    typedef logic [GEST_W-1:0]     t_gest;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // pointer event kinds
    localparam t_mode MODE_MOVE    = 2'd0;
    localparam t_mode MODE_PRESS   = 2'd1;
    localparam t_mode MODE_RELEASE = 2'd2;

    // result kinds
    localparam t_kind KIND_NONE    = 2'd0;
    localparam t_kind KIND_PRESS   = 2'd1;
    localparam t_kind KIND_RELEASE = 2'd2;
    localparam t_kind KIND_FWD     = 2'd3;

    // latched gestures
    localparam t_gest GEST_NONE   = 2'd0;
    localparam t_gest GEST_VERT   = 2'd1;
    localparam t_gest GEST_HORIZ  = 2'd2;
    localparam t_gest GEST_CIRCLE = 2'd3;

    // register map
    localparam t_cfg_idx CFG_TOL = 1'b0;
    localparam t_cfg_idx CFG_THR = 1'b1;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd3277;
    localparam logic [THR_W-1:0] THR_RESET = 8'd10;

    // sample count saturates here; cosines start at this count
    localparam logic [1:0] SAMPLES_FULL = 2'd2;

endpackage

/* hdl/dgc_evt_if.sv */
// ----------------------------------------------------------------------------
// dgc_evt_if: pointer event channel
// Valid/ready channel carrying one pointer event per request.
// ----------------------------------------------------------------------------
interface dgc_evt_if import dgc_pkg::*; #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    t_mode                        mode;
    t_btn                         button_id;
    logic signed [COORD_BITS-1:0] x_pos;
    logic signed [COORD_BITS-1:0] y_pos;

    modport source (output valid, mode, button_id, x_pos, y_pos, input ready);
    modport sink   (input valid, mode, button_id, x_pos, y_pos, output ready);
endinterface

/* hdl/dgc_res_if.sv */
// ----------------------------------------------------------------------------
// dgc_res_if: classifier result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface dgc_res_if import dgc_pkg::*; #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    t_kind                        event_kind;
    t_gest                        gesture;
    logic                         held_valid;
    t_btn                         held_button;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;

    modport source (output valid, event_kind, gesture, held_valid, held_button,
                    out_x, out_y, input ready);
    modport sink   (input valid, event_kind, gesture, held_valid, held_button,
                    out_x, out_y, output ready);
endinterface

/* hdl/drag_gesture_classifier_core.sv */
// ----------------------------------------------------------------------------
// drag_gesture_classifier_core: drag gesture classifier
// Pointer events in (i_evt), one result per event out (o_res). Each event is
// a request on a valid/ready channel; configuration is a plain write port
// (i_cfg_we, i_cfg_index, i_cfg_data) to be used only while the block is idle;
// the user must keep to this, the block does not enforce it. Press, release,
// forwarded and absorbed moves pass through decode and emit to the output
// register. A sampling move (every second move while a button is held and
// no gesture is latched) runs through one shared (COORD_BITS+1)-bit
// multiplier for 10 products, then a bit-pair square root and a
// FRACTION_BITS+1 bit restoring divide on its way to the output register.
// A zero-length motion skips the root and divide, and the first sampling
// move after a press only records its motion.
// One event is in work at a time; i_evt.ready is high only while idle, and
// a finished result waits in the output register while the next event is
// taken. When the receiver stalls, a second result holds in the core until
// the output register frees up. Reset (synchronous, active low) drops any
// pending result, clears the tracking state and restores register values.
// ----------------------------------------------------------------------------
module drag_gesture_classifier_core import dgc_pkg::*; #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 15,
    parameter int TALLY_BITS    = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dgc_evt_if.sink    i_evt,
    dgc_res_if.source  o_res,
    input  logic       i_cfg_we,
    input  t_cfg_idx   i_cfg_index,
    input  t_cfg_data  i_cfg_data
);

    localparam int H     = COORD_BITS + 1;      // delta and magnitude width
    localparam int PW    = 2 * H;               // product width
    localparam int P4W   = 4 * H;               // |a|^2 * |b|^2 width
    localparam int RW    = 2 * H + 2;           // root remainder width
    localparam int DRW   = 2 * H + 1;           // divide remainder width
    localparam int QW    = FRACTION_BITS + 1;
    localparam int CW    = FRACTION_BITS + 2;   // signed cosine width
    localparam int DIFW  = (FRACTION_BITS + 3 > TOL_W + 1) ? FRACTION_BITS + 3 : TOL_W + 1;
    localparam int TCW   = (TALLY_BITS > THR_W) ? TALLY_BITS : THR_W;
    localparam int ITERS = (2 * H > QW) ? 2 * H : QW;
    localparam int CNT_W = $clog2(ITERS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_ACC    = 3'd3;
    localparam logic [2:0] S_SQRT   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    // product steps of the shared multiplier
    localparam logic [CNT_W-1:0] P_AXX = CNT_W'(0);
    localparam logic [CNT_W-1:0] P_AYY = CNT_W'(1);
    localparam logic [CNT_W-1:0] P_BXX = CNT_W'(2);
    localparam logic [CNT_W-1:0] P_BYY = CNT_W'(3);
    localparam logic [CNT_W-1:0] P_AXB = CNT_W'(4);
    localparam logic [CNT_W-1:0] P_AYB = CNT_W'(5);
    localparam logic [CNT_W-1:0] P_LL  = CNT_W'(6);
    localparam logic [CNT_W-1:0] P_LH  = CNT_W'(7);
    localparam logic [CNT_W-1:0] P_HL  = CNT_W'(8);
    localparam logic [CNT_W-1:0] P_HH  = CNT_W'(9);

    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(2 * H - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QW - 1);
    localparam logic [TALLY_BITS-1:0] TALLY_MAX = {TALLY_BITS{1'b1}};

    function automatic logic [H-1:0] f_mag(input logic [H-1:0] v);
        return v[H-1] ? (~v + 1'b1) : v;
    endfunction

    // control and config
    logic [2:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_step, n_step;
    logic [TOL_W-1:0]       r_tol, n_tol;
    logic [THR_W-1:0]       r_thr, n_thr;
    // captured event
    t_mode                  r_mode, n_mode;
    t_btn                   r_btn, n_btn;
    logic [COORD_BITS-1:0]  r_x, n_x;
    logic [COORD_BITS-1:0]  r_y, n_y;
    t_kind                  r_kind, n_kind;
    // tracking state
    logic                   r_holding, n_holding;
    t_btn                   r_held_id, n_held_id;
    t_gest                  r_latched, n_latched;
    logic                   r_parity, n_parity;
    logic [1:0]             r_samples, n_samples;
    logic [COORD_BITS-1:0]  r_last_x, n_last_x;
    logic [COORD_BITS-1:0]  r_last_y, n_last_y;
    logic [H-1:0]           r_mdx, n_mdx;
    logic [H-1:0]           r_mdy, n_mdy;
    logic [CW-1:0]          r_prev_cos, n_prev_cos;
    logic                   r_prev_def, n_prev_def;
    logic [TALLY_BITS-1:0]  r_circ, n_circ;
    logic [TALLY_BITS-1:0]  r_straight, n_straight;
    // arithmetic datapath
    logic [H-1:0]           r_max, n_max, r_may, n_may, r_mbx, n_mbx, r_mby, n_mby;
    logic                   r_sax, n_sax, r_say, n_say, r_sbx, n_sbx, r_sby, n_sby;
    logic [PW-1:0]          r_prod, n_prod;
    logic [PW-1:0]          r_la, n_la, r_lb, n_lb, r_sx, n_sx, r_sy, n_sy;
    logic [PW:0]            r_dot, n_dot;
    logic [P4W-1:0]         r_p, n_p;
    logic [RW-1:0]          r_rem, n_rem;
    logic [PW-1:0]          r_root, n_root;
    logic [DRW-1:0]         r_drem, n_drem;
    logic [QW-1:0]          r_q, n_q;
    // output register
    logic                   r_out_valid, n_out_valid;
    t_kind                  r_o_kind, n_o_kind;
    t_gest                  r_o_gest, n_o_gest;
    logic                   r_o_hv, n_o_hv;
    t_btn                   r_o_hb, n_o_hb;
    logic [COORD_BITS-1:0]  r_o_x, n_o_x, r_o_y, n_o_y;

    // combinational helpers
    logic [H-1:0]           dx_new, dy_new;
    logic [H-1:0]           op_a, op_b;
    logic [PW-1:0]          mul_out;
    logic                   term_neg;
    logic [PW:0]            term;
    logic [RW-1:0]          sq_rem2, sq_trial;
    logic [PW-1:0]          dot_mag;
    logic                   div_bit;
    logic [DRW-1:0]         dv_rem2;
    logic                   cos_def;
    logic [CW-1:0]          cur_mag, cur_cos;
    logic [DIFW-1:0]        cos_diff, cos_adiff;
    logic                   steady;
    logic [PW-1:0]          sq_ad;
    logic [PW+2:0]          diag_lhs, diag_rhs;
    logic                   is_circ;
    logic [TCW-1:0]         straight_ext, circ_ext, thr_ext;

    assign i_evt.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.event_kind  = r_o_kind;
    assign o_res.gesture     = r_o_gest;
    assign o_res.held_valid  = r_o_hv;
    assign o_res.held_button = r_o_hb;
    assign o_res.out_x       = r_o_x;
    assign o_res.out_y       = r_o_y;

    assign dx_new = {r_x[COORD_BITS-1], r_x} - {r_last_x[COORD_BITS-1], r_last_x};
    assign dy_new = {r_y[COORD_BITS-1], r_y} - {r_last_y[COORD_BITS-1], r_last_y};

    // operand select for the shared multiplier
    always_comb begin
        op_a     = r_max;
        op_b     = r_max;
        term_neg = 1'b0;
        case (r_step)
            P_AXX: begin op_a = r_max; op_b = r_max; end
            P_AYY: begin op_a = r_may; op_b = r_may; end
            P_BXX: begin op_a = r_mbx; op_b = r_mbx; end
            P_BYY: begin op_a = r_mby; op_b = r_mby; end
            P_AXB: begin op_a = r_max; op_b = r_mbx; term_neg = r_sax ^ r_sbx; end
            P_AYB: begin op_a = r_may; op_b = r_mby; term_neg = r_say ^ r_sby; end
            P_LL:  begin op_a = r_la[H-1:0];  op_b = r_lb[H-1:0];  end
            P_LH:  begin op_a = r_la[H-1:0];  op_b = r_lb[PW-1:H]; end
            P_HL:  begin op_a = r_la[PW-1:H]; op_b = r_lb[H-1:0];  end
            P_HH:  begin op_a = r_la[PW-1:H]; op_b = r_lb[PW-1:H]; end
            default: begin op_a = r_max; op_b = r_max; end
        endcase
    end

    // full-width product of the two operands
    assign mul_out = op_a * op_b;

    assign term = term_neg ? (~{1'b0, r_prod} + 1'b1) : {1'b0, r_prod};

    // square root: one result bit per cycle
    assign sq_rem2  = {r_rem[RW-3:0], r_p[P4W-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};

    // divide: first brought-down bit is the low bit of |dot|, then zeros
    assign dot_mag = r_dot[PW] ? PW'(~r_dot + 1'b1) : r_dot[PW-1:0];
    assign div_bit = (r_step == '0) ? dot_mag[0] : 1'b0;
    assign dv_rem2 = {r_drem[DRW-2:0], div_bit};

    // sample classification
    assign cos_def   = (r_la != '0) && (r_lb != '0);
    assign cur_mag   = {1'b0, r_q};
    assign cur_cos   = r_dot[PW] ? (~cur_mag + 1'b1) : cur_mag;
    assign cos_diff  = {{(DIFW-CW){cur_cos[CW-1]}}, cur_cos}
                     - {{(DIFW-CW){r_prev_cos[CW-1]}}, r_prev_cos};
    assign cos_adiff = cos_diff[DIFW-1] ? (~cos_diff + 1'b1) : cos_diff;
    assign steady    = cos_adiff < DIFW'(r_tol);
    assign sq_ad     = (r_sx > r_sy) ? (r_sx - r_sy) : (r_sy - r_sx);
    // diagonal when 5*|sx - sy| < 4*(sx + sy)
    assign diag_lhs  = {1'b0, sq_ad, 2'b00} + (PW+3)'(sq_ad);
    assign diag_rhs  = {(PW+1)'(r_sx) + (PW+1)'(r_sy), 2'b00};
    assign is_circ   = !cos_def || !r_prev_def || !steady || (diag_lhs < diag_rhs);
    assign thr_ext   = TCW'(r_thr);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_tol       = r_tol;
        n_thr       = r_thr;
        n_mode      = r_mode;
        n_btn       = r_btn;
        n_x         = r_x;
        n_y         = r_y;
        n_kind      = r_kind;
        n_holding   = r_holding;
        n_held_id   = r_held_id;
        n_latched   = r_latched;
        n_parity    = r_parity;
        n_samples   = r_samples;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_mdx       = r_mdx;
        n_mdy       = r_mdy;
        n_prev_cos  = r_prev_cos;
        n_prev_def  = r_prev_def;
        n_circ      = r_circ;
        n_straight  = r_straight;
        n_max       = r_max;
        n_may       = r_may;
        n_mbx       = r_mbx;
        n_mby       = r_mby;
        n_sax       = r_sax;
        n_say       = r_say;
        n_sbx       = r_sbx;
        n_sby       = r_sby;
        n_prod      = r_prod;
        n_la        = r_la;
        n_lb        = r_lb;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_dot       = r_dot;
        n_p         = r_p;
        n_rem       = r_rem;
        n_root      = r_root;
        n_drem      = r_drem;
        n_q         = r_q;
        n_out_valid = r_out_valid;
        n_o_kind    = r_o_kind;
        n_o_gest    = r_o_gest;
        n_o_hv      = r_o_hv;
        n_o_hb      = r_o_hb;
        n_o_x       = r_o_x;
        n_o_y       = r_o_y;
        straight_ext = TCW'(r_straight);
        circ_ext     = TCW'(r_circ);

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TOL: n_tol = i_cfg_data[TOL_W-1:0];
                CFG_THR: n_thr = i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_evt.valid) begin
                    n_mode  = i_evt.mode;
                    n_btn   = i_evt.button_id;
                    n_x     = i_evt.x_pos;
                    n_y     = i_evt.y_pos;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_kind  = KIND_NONE;
                n_state = S_EMIT;
                case (r_mode)
                    MODE_PRESS: begin
                        if (!r_holding) begin
                            n_holding  = 1'b1;
                            n_held_id  = r_btn;
                            n_latched  = GEST_NONE;
                            n_parity   = 1'b0;
                            n_samples  = '0;
                            n_last_x   = '0;
                            n_last_y   = '0;
                            n_mdx      = {r_x[COORD_BITS-1], r_x};
                            n_mdy      = {r_y[COORD_BITS-1], r_y};
                            n_prev_cos = '0;
                            n_prev_def = 1'b1;
                            n_circ     = '0;
                            n_straight = '0;
                            n_kind     = KIND_PRESS;
                        end
                    end
                    MODE_RELEASE: begin
                        if (r_holding && (r_held_id == r_btn)) begin
                            n_holding = 1'b0;
                            n_kind    = KIND_RELEASE;
                        end
                    end
                    MODE_MOVE: begin
                        if (r_latched != GEST_NONE) begin
                            n_kind = KIND_FWD;
                        end else if (r_holding) begin
                            n_parity = ~r_parity;
                            if (r_parity) begin
                                // sampling move: old motion is a, new motion is b
                                if (r_samples != SAMPLES_FULL) begin
                                    n_samples = r_samples + 2'd1;
                                end
                                n_last_x = r_x;
                                n_last_y = r_y;
                                n_mdx    = dx_new;
                                n_mdy    = dy_new;
                                n_max    = f_mag(r_mdx);
                                n_may    = f_mag(r_mdy);
                                n_sax    = r_mdx[H-1];
                                n_say    = r_mdy[H-1];
                                n_mbx    = f_mag(dx_new);
                                n_mby    = f_mag(dy_new);
                                n_sbx    = dx_new[H-1];
                                n_sby    = dy_new[H-1];
                                if (r_samples != '0) begin
                                    n_step  = P_AXX;
                                    n_state = S_MUL;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end

            S_MUL: begin
                n_prod  = mul_out;
                n_state = S_ACC;
            end

            S_ACC: begin
                n_step  = r_step + 1'b1;
                n_state = S_MUL;
                case (r_step)
                    P_AXX: n_la = r_prod;
                    P_AYY: n_la = r_la + r_prod;
                    P_BXX: n_sx = r_prod;
                    P_BYY: begin
                        n_sy = r_prod;
                        n_lb = r_sx + r_prod;
                    end
                    P_AXB: n_dot = term;
                    P_AYB: begin
                        n_dot = r_dot + term;
                        // zero-length vector: no cosine
                        if (!cos_def) begin
                            n_state = S_FINISH;
                        end
                    end
                    P_LL:  n_p = P4W'(r_prod);
                    P_LH:  n_p = r_p + (P4W'(r_prod) << H);
                    P_HL:  n_p = r_p + (P4W'(r_prod) << H);
                    P_HH: begin
                        n_p     = r_p + (P4W'(r_prod) << (2 * H));
                        n_rem   = '0;
                        n_root  = '0;
                        n_step  = '0;
                        n_state = S_SQRT;
                    end
                    default: ;
                endcase
            end

            S_SQRT: begin
                n_p    = r_p << 2;
                n_step = r_step + 1'b1;
                if (sq_rem2 >= sq_trial) begin
                    n_rem  = sq_rem2 - sq_trial;
                    n_root = {r_root[PW-2:0], 1'b1};
                end else begin
                    n_rem  = sq_rem2;
                    n_root = {r_root[PW-2:0], 1'b0};
                end
                if (r_step == SQRT_LAST) begin
                    n_drem  = {2'b00, dot_mag[PW-1:1]};
                    n_q     = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end
            end

            S_DIV: begin
                n_step = r_step + 1'b1;
                if (dv_rem2 >= {1'b0, r_root}) begin
                    n_drem = dv_rem2 - {1'b0, r_root};
                    n_q    = {r_q[QW-2:0], 1'b1};
                end else begin
                    n_drem = dv_rem2;
                    n_q    = {r_q[QW-2:0], 1'b0};
                end
                if (r_step == DIV_LAST) begin
                    n_state = S_FINISH;
                end
            end

            S_FINISH: begin
                n_prev_cos = cos_def ? cur_cos : '0;
                n_prev_def = cos_def;
                if (is_circ) begin
                    if (r_circ != TALLY_MAX) begin
                        n_circ = r_circ + 1'b1;
                    end
                end else begin
                    if (r_straight != TALLY_MAX) begin
                        n_straight = r_straight + 1'b1;
                    end
                end
                straight_ext = TCW'(n_straight);
                circ_ext     = TCW'(n_circ);
                if (straight_ext > thr_ext) begin
                    n_latched = (r_sx < r_sy) ? GEST_VERT : GEST_HORIZ;
                end else if (circ_ext > thr_ext) begin
                    n_latched = GEST_CIRCLE;
                end
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = r_kind;
                    n_o_gest    = r_latched;
                    n_o_hv      = r_holding;
                    n_o_hb      = r_holding ? r_held_id : '0;
                    n_o_x       = r_x;
                    n_o_y       = r_y;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_tol       <= TOL_RESET;
            r_thr       <= THR_RESET;
            r_holding   <= 1'b0;
            r_held_id   <= '0;
            r_latched   <= GEST_NONE;
            r_parity    <= 1'b0;
            r_samples   <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_mdx       <= '0;
            r_mdy       <= '0;
            r_prev_cos  <= '0;
            r_prev_def  <= 1'b1;
            r_circ      <= '0;
            r_straight  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_tol       <= n_tol;
            r_thr       <= n_thr;
            r_holding   <= n_holding;
            r_held_id   <= n_held_id;
            r_latched   <= n_latched;
            r_parity    <= n_parity;
            r_samples   <= n_samples;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
            r_mdx       <= n_mdx;
            r_mdy       <= n_mdy;
            r_prev_cos  <= n_prev_cos;
            r_prev_def  <= n_prev_def;
            r_circ      <= n_circ;
            r_straight  <= n_straight;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_btn    <= n_btn;
        r_x      <= n_x;
        r_y      <= n_y;
        r_kind   <= n_kind;
        r_max    <= n_max;
        r_may    <= n_may;
        r_mbx    <= n_mbx;
        r_mby    <= n_mby;
        r_sax    <= n_sax;
        r_say    <= n_say;
        r_sbx    <= n_sbx;
        r_sby    <= n_sby;
        r_prod   <= n_prod;
        r_la     <= n_la;
        r_lb     <= n_lb;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_dot    <= n_dot;
        r_p      <= n_p;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_drem   <= n_drem;
        r_q      <= n_q;
        r_o_kind <= n_o_kind;
        r_o_gest <= n_o_gest;
        r_o_hv   <= n_o_hv;
        r_o_hb   <= n_o_hb;
        r_o_x    <= n_o_x;
        r_o_y    <= n_o_y;
    end

endmodule

/* bench/drag_gesture_classifier_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drag_gesture_classifier_core_tb: self-checking bench for the classifier
// Drives pointer events with random gaps and result back-pressure, predicts
// each result with an in-bench tracker model and checks every result in order.
// ----------------------------------------------------------------------------
module drag_gesture_classifier_core_tb;
    import dgc_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 33;
    localparam int TALLY_MAX   = 255;
    localparam longint Q_ONE   = 64'd32768;

    // mode code the block must ignore
    localparam t_mode MODE_SPARE = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_kind  kind;
        t_gest  gesture;
        logic   held;
        t_btn   button;
        t_coord x;
        t_coord y;
    } t_result;

    typedef enum int {PATH_LINE, PATH_RING, PATH_SCATTER} t_path;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_index;
    t_cfg_data cfg_data;

    dgc_evt_if #(.COORD_BITS(COORD_BITS)) evt ();
    dgc_res_if #(.COORD_BITS(COORD_BITS)) res ();

    drag_gesture_classifier_core #(.COORD_BITS(COORD_BITS)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_evt       (evt),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // tracker copy
    logic          trk_holding;
    t_btn          trk_button;
    t_gest         trk_gesture;
    logic          trk_parity;
    int            trk_samples;
    longint        trk_last_x, trk_last_y;
    longint        trk_dx, trk_dy;
    longint        trk_prev_cos;
    logic          trk_prev_defined;
    int            trk_circles, trk_straights;
    logic [15:0]   cfg_tolerance;
    logic [7:0]    cfg_threshold;

    t_result event_outcomes[$];
    int      mismatches    = 0;
    int      results_seen  = 0;
    int      shaped_events = 0;
    bit      no_idle       = 1'b0;

    // ------------------------------------------------------------------
    // tracker model
    // ------------------------------------------------------------------
    function automatic void clear_tracking();
        trk_gesture      = GEST_NONE;
        trk_parity       = 1'b0;
        trk_samples      = 0;
        trk_last_x       = 0;
        trk_last_y       = 0;
        trk_dx           = 0;
        trk_dy           = 0;
        trk_prev_cos     = 0;
        trk_prev_defined = 1'b1;
        trk_circles      = 0;
        trk_straights    = 0;
    endfunction

    // Q1.15 turn cosine; returns 0 when either vector has zero length
    function automatic bit turn_cosine(input longint ax, input longint ay,
                                       input longint bx, input longint by,
                                       output longint cos_q);
        longint unsigned len_a, len_b;
        longint          dot;
        longint unsigned mag;
        bit [127:0]      prod, num, trial, root, quot;
        int              b;
        len_a = ax * ax + ay * ay;
        len_b = bx * bx + by * by;
        dot   = ax * bx + ay * by;
        cos_q = 0;
        if (len_a == 0 || len_b == 0)
            return 1'b0;
        prod = len_a;
        prod = prod * len_b;
        root = '0;
        for (b = 63; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= prod)
                root = trial;
        end
        mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        num = mag;
        num = num << 15;
        quot = '0;
        for (b = 15; b >= 0; b--) begin
            trial = quot | (128'd1 << b);
            if (trial * root <= num)
                quot = trial;
        end
        if (quot > Q_ONE)
            quot = Q_ONE;
        cos_q = (dot < 0) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
        return 1'b1;
    endfunction

    function automatic void take_sample(input longint x, input longint y);
        longint          ax, ay, px, py, cur, diff;
        longint unsigned sq_x, sq_y, gap;
        bit              defined, circ;
        ax = trk_dx;
        ay = trk_dy;
        px = trk_last_x;
        py = trk_last_y;
        if (trk_samples < 2)
            trk_samples++;
        trk_last_x = x;
        trk_last_y = y;
        trk_dx     = x - px;
        trk_dy     = y - py;
        if (trk_samples < 2)
            return;
        defined = turn_cosine(ax, ay, trk_dx, trk_dy, cur);
        sq_x = trk_dx * trk_dx;
        sq_y = trk_dy * trk_dy;
        if (!defined || !trk_prev_defined) begin
            circ = 1'b1;
        end else begin
            diff = cur - trk_prev_cos;
            if (diff < 0)
                diff = -diff;
            if (diff < longint'(cfg_tolerance)) begin
                // diagonal motion is never straight
                gap  = (sq_x > sq_y) ? sq_x - sq_y : sq_y - sq_x;
                circ = (5 * gap < 4 * (sq_x + sq_y));
            end else begin
                circ = 1'b1;
            end
        end
        trk_prev_cos     = defined ? cur : 0;
        trk_prev_defined = defined;
        if (circ) begin
            if (trk_circles < TALLY_MAX)
                trk_circles++;
        end else begin
            if (trk_straights < TALLY_MAX)
                trk_straights++;
        end
        if (trk_straights > int'(cfg_threshold))
            trk_gesture = (sq_x < sq_y) ? GEST_VERT : GEST_HORIZ;
        else if (trk_circles > int'(cfg_threshold))
            trk_gesture = GEST_CIRCLE;
    endfunction

    function automatic t_result classify_pointer_event(input t_mode m, input t_btn b,
                                                       input t_coord x, input t_coord y);
        t_result r;
        r.kind = KIND_NONE;
        if (m == MODE_PRESS) begin
            if (!trk_holding) begin
                trk_holding = 1'b1;
                trk_button  = b;
                clear_tracking();
                trk_dx = longint'(x);
                trk_dy = longint'(y);
                r.kind = KIND_PRESS;
            end
        end else if (m == MODE_RELEASE) begin
            if (trk_holding && trk_button == b) begin
                trk_holding = 1'b0;
                r.kind      = KIND_RELEASE;
            end
        end else if (m == MODE_MOVE) begin
            if (trk_gesture != GEST_NONE) begin
                r.kind = KIND_FWD;
            end else if (trk_holding) begin
                trk_parity = ~trk_parity;
                if (!trk_parity)
                    take_sample(longint'(x), longint'(y));
            end
        end
        r.gesture = trk_gesture;
        r.held    = trk_holding;
        r.button  = trk_holding ? trk_button : t_btn'(0);
        r.x       = x;
        r.y       = y;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic string describe(input t_result r);
        return $sformatf("kind=%0d gesture=%0d held=%0d button=%0d x=%0d y=%0d",
                         r.kind, r.gesture, r.held, r.button, r.x, r.y);
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", what);
    endtask

    always @(negedge clk) begin
        res.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && res.valid && res.ready) begin
            got.kind    = res.event_kind;
            got.gesture = res.gesture;
            got.held    = res.held_valid;
            got.button  = res.held_button;
            got.x       = res.out_x;
            got.y       = res.out_y;
            if (event_outcomes.size() == 0) begin
                flag_mismatch($sformatf("result %0d with nothing pending: %s",
                                        results_seen, describe(got)));
            end else begin
                want = event_outcomes.pop_front();
                if (got !== want)
                    flag_mismatch($sformatf("result %0d mismatch: expected %s, got %s",
                                            results_seen, describe(want), describe(got)));
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((evt.valid && evt.ready) || (res.valid && res.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers; all entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_event(input t_mode m, input t_btn b, input t_coord x, input t_coord y);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            evt.valid <= 1'b0;
            @(negedge clk);
        end
        evt.valid     <= 1'b1;
        evt.mode      <= m;
        evt.button_id <= b;
        evt.x_pos     <= x;
        evt.y_pos     <= y;
        @(posedge clk);
        while (!evt.ready)
            @(posedge clk);
        event_outcomes.push_back(classify_pointer_event(m, b, x, y));
        @(negedge clk);
    endtask

    // registers change only with the block drained
    task automatic program_classifier(input logic [15:0] tol, input logic [7:0] thr);
        evt.valid <= 1'b0;
        while (event_outcomes.size() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOL;
        cfg_data  <= tol;
        @(negedge clk);
        cfg_index <= CFG_THR;
        cfg_data  <= t_cfg_data'(thr);
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_tolerance = tol;
        cfg_threshold = thr;
        @(negedge clk);
    endtask

    // eight headings around a circle, scaled by 8
    function automatic int ring_cos(input int k);
        case (k % 8)
            0:       return 8;
            1:       return 6;
            2:       return 0;
            3:       return -6;
            4:       return -8;
            5:       return -6;
            6:       return 0;
            default: return 6;
        endcase
    endfunction

    // press, a path of moves, then usually a release
    task automatic drag_sequence(input t_path shape, input int min_moves, input int max_moves);
        t_btn btn;
        int   px, py, sx, sy, k, turn, scale, n, i, pick;
        btn   = t_btn'($urandom_range(7));
        px    = int'($urandom_range(4000)) - 2000;
        py    = int'($urandom_range(4000)) - 2000;
        k     = $urandom_range(7);
        turn  = $urandom_range(1) ? 1 : 7;
        scale = $urandom_range(20, 1);
        if ($urandom_range(1)) begin
            sx = int'($urandom_range(80)) - 40;
            sy = int'($urandom_range(6)) - 3;
        end else begin
            sx = int'($urandom_range(6)) - 3;
            sy = int'($urandom_range(80)) - 40;
        end
        n = $urandom_range(max_moves, min_moves);
        send_event(MODE_PRESS, btn, t_coord'(px), t_coord'(py));
        for (i = 0; i < n; i++) begin
            case (shape)
                PATH_LINE: begin
                    px += sx;
                    py += sy;
                    if ($urandom_range(4) == 0) begin
                        px += int'($urandom_range(4)) - 2;
                        py += int'($urandom_range(4)) - 2;
                    end
                end
                PATH_RING: begin
                    k  = (k + turn) % 8;
                    px += scale * ring_cos(k);
                    py += scale * ring_cos(k + 6);
                end
                default: begin
                    px = int'($urandom_range(65535));
                    py = int'($urandom_range(65535));
                end
            endcase
            send_event(MODE_MOVE, t_btn'($urandom_range(7)), t_coord'(px), t_coord'(py));
        end
        pick = $urandom_range(9);
        if (pick == 1)
            send_event(MODE_RELEASE, btn ^ t_btn'($urandom_range(7, 1)), t_coord'(px),
                       t_coord'(py));
        if (pick != 0)
            send_event(MODE_RELEASE, btn, t_coord'(px), t_coord'(py));
        // moves after the release are forwarded only with a latched gesture
        if ($urandom_range(9) < 3) begin
            repeat ($urandom_range(3, 1))
                send_event(MODE_MOVE, btn, t_coord'($urandom_range(65535)),
                           t_coord'($urandom_range(65535)));
        end
        shaped_events += n + 2;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_event_handling();
        send_event(MODE_MOVE, 3'd0, -16'sd32768, 16'sd32767);   // absorbed, nothing held
        send_event(MODE_RELEASE, 3'd0, 16'sd0, 16'sd0);         // release while not holding
        send_event(MODE_SPARE, 3'd5, 16'sd1, -16'sd1);          // unused mode
        send_event(MODE_PRESS, 3'd7, 16'sd32767, -16'sd32768);
        send_event(MODE_PRESS, 3'd2, 16'sd5, 16'sd5);           // press while holding
        send_event(MODE_RELEASE, 3'd3, 16'sd0, 16'sd0);         // other button
        send_event(MODE_MOVE, 3'd0, 16'sd100, 16'sd100);
        send_event(MODE_MOVE, 3'd0, 16'sd200, 16'sd100);
        send_event(MODE_MOVE, 3'd0, 16'sd0, 16'sd0);
        // same point again: zero-length motion, undefined cosine
        send_event(MODE_MOVE, 3'd0, 16'sd200, 16'sd100);
        send_event(MODE_RELEASE, 3'd7, 16'sd0, 16'sd0);
    endtask

    task automatic test_gesture_latching();
        // a sudden cosine change counts as circular and latches at threshold 0
        program_classifier(TOL_RESET, 8'd0);
        send_event(MODE_PRESS, 3'd1, 16'sd0, 16'sd0);
        send_event(MODE_MOVE, 3'd1, 16'sd5, 16'sd0);
        send_event(MODE_MOVE, 3'd1, 16'sd10, 16'sd0);
        send_event(MODE_MOVE, 3'd1, 16'sd15, 16'sd0);
        send_event(MODE_MOVE, 3'd1, 16'sd20, 16'sd0);
        send_event(MODE_MOVE, 3'd1, 16'sd25, 16'sd0);
        send_event(MODE_RELEASE, 3'd1, 16'sd0, 16'sd0);
        send_event(MODE_MOVE, 3'd1, -16'sd1, -16'sd1);          // forwarded, nothing held
        // widest tolerance: a reversal along y is straight, vertical
        program_classifier(16'hFFFF, 8'd0);
        send_event(MODE_PRESS, 3'd4, 16'sd0, 16'sd0);
        send_event(MODE_MOVE, 3'd4, 16'sd0, 16'sd5);
        send_event(MODE_MOVE, 3'd4, 16'sd0, 16'sd10);
        send_event(MODE_MOVE, 3'd4, 16'sd0, 16'sd0);
        send_event(MODE_MOVE, 3'd4, 16'sd0, -16'sd32768);
        send_event(MODE_RELEASE, 3'd4, 16'sd0, 16'sd0);
    endtask

    // one long drag with no idling: tally runs up to the top threshold
    task automatic test_tally_limit();
        int px, py, k, i;
        program_classifier(16'd0, 8'd254);
        no_idle = 1'b1;
        px = 0;
        py = 0;
        k  = 0;
        send_event(MODE_PRESS, 3'd6, 16'sd0, 16'sd0);
        for (i = 0; i < 530; i++) begin
            k  = (k + 1) % 8;
            px += int'($urandom_range(30, 1)) * ring_cos(k);
            py += int'($urandom_range(30, 1)) * ring_cos(k + 6);
            send_event(MODE_MOVE, 3'd6, t_coord'(px), t_coord'(py));
        end
        send_event(MODE_RELEASE, 3'd6, 16'sd0, 16'sd0);
        no_idle = 1'b0;
    endtask

    task automatic test_random_drags();
        int          phase, target, pick;
        logic [15:0] tol;
        logic [7:0]  thr;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       begin tol = TOL_RESET;          thr = THR_RESET;                 end
                1:       begin tol = 16'd0;              thr = 8'd0;                      end
                2:       begin tol = 16'hFFFF;           thr = 8'd254;                    end
                3:       begin tol = 16'hFFFF;           thr = 8'd0;                      end
                4:       begin tol = 16'd1000;           thr = 8'd3;                      end
                5:       begin tol = 16'($urandom_range(65535)); thr = 8'($urandom_range(12)); end
                6:       begin tol = 16'd20000;          thr = 8'd1;                      end
                default: begin tol = 16'($urandom_range(65535)); thr = 8'($urandom_range(6)); end
            endcase
            program_classifier(tol, thr);
            target = shaped_events + 45;
            while (shaped_events < target) begin
                pick = $urandom_range(99);
                if (pick < 40)
                    drag_sequence(PATH_LINE, 4, 48);
                else if (pick < 72)
                    drag_sequence(PATH_RING, 4, 48);
                else if (pick < 84)
                    drag_sequence(PATH_SCATTER, 2, 30);
                else
                    repeat ($urandom_range(4, 1))
                        send_event(t_mode'($urandom_range(3)), t_btn'($urandom_range(7)),
                                   t_coord'($urandom_range(65535)),
                                   t_coord'($urandom_range(65535)));
            end
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        evt.valid     = 1'b0;
        evt.mode      = MODE_MOVE;
        evt.button_id = '0;
        evt.x_pos     = '0;
        evt.y_pos     = '0;
        res.ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_TOL;
        cfg_data      = '0;
        trk_holding   = 1'b0;
        trk_button    = '0;
        clear_tracking();
        cfg_tolerance = TOL_RESET;
        cfg_threshold = THR_RESET;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_event_handling();
        test_gesture_latching();
        test_tally_limit();
        test_random_drags();

        evt.valid <= 1'b0;
        while (event_outcomes.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* drag_gesture_classifier_core.f */
hdl/dgc_pkg.sv
hdl/dgc_evt_if.sv
hdl/dgc_res_if.sv
hdl/drag_gesture_classifier_core.sv
bench/drag_gesture_classifier_core_tb.sv
